>>> design/htd_pkg.sv
// ============================================================================
// Huffman tree decoder package
// Shared types and codes for the node-table Huffman decoder.
// ============================================================================
`default_nettype none

package htd_pkg;

    // Width of a symbol, a coded byte and the code word.
    localparam int SymW  = 8;
    localparam int CodeW = 32;
    localparam int LenW  = 6;
    localparam int CntW  = 4;

    // Input modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Result kinds.
    localparam logic KIND_SYM = 1'b0;
    localparam logic KIND_RPT = 1'b1;

    // Status codes of a result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    // Walk sequencer states.
    typedef enum logic [3:0] {
        W_IDLE,
        W_I_RD,
        W_I_EV,
        W_I_WN,
        W_RES,
        W_D_RD,
        W_D_EV,
        W_D_CHK,
        W_END
    } t_state;

    // One result item without its last flag.
    typedef struct packed {
        logic [SymW-1:0] sym;
        logic            kind;
        t_status         status;
    } t_res;

    // Command from the walk sequencer to the result stage.
    typedef struct packed {
        logic push;
        logic flush;
        t_res res;
    } t_res_cmd;

endpackage

`default_nettype wire

>>> design/htd_in_if.sv
// ============================================================================
// Huffman tree decoder input channel
// Valid/ready channel that carries one insert or decode request.
// ============================================================================
`default_nettype none

interface htd_in_if
    import htd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [SymW-1:0]  symbol_in;
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_len;
    logic [SymW-1:0]  data_byte;
    logic [CntW-1:0]  bit_count;

    modport source (
        output valid, mode, symbol_in, code_bits, code_len, data_byte, bit_count,
        input  ready
    );

    modport sink (
        input  valid, mode, symbol_in, code_bits, code_len, data_byte, bit_count,
        output ready
    );
endinterface

`default_nettype wire

>>> design/htd_out_if.sv
// ============================================================================
// Huffman tree decoder output channel
// Valid/ready channel that carries one result request.
// ============================================================================
`default_nettype none

interface htd_out_if
    import htd_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [SymW-1:0] symbol_out;
    logic            kind;
    logic [1:0]      status;
    logic            last;

    modport source (
        output valid, symbol_out, kind, status, last,
        input  ready
    );

    modport sink (
        input  valid, symbol_out, kind, status, last,
        output ready
    );
endinterface

`default_nettype wire

>>> design/htd_node_mem.sv
// ============================================================================
// Huffman tree decoder node memory
// Simple dual-port node table: one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module htd_node_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 27
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/htd_result.sv
// ============================================================================
// Huffman tree decoder result stage
// Holds the newest result until it is known whether it is the last one of
// its request, then moves it into the output register.
// ============================================================================
`default_nettype none

module htd_result
    import htd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_res_cmd i_cmd,
    output logic          o_cmd_ready,
    htd_out_if.source     o_out
);

    logic r_hold_vld;
    t_res r_hold;
    logic r_out_vld;
    t_res r_out;
    logic r_out_last;

    logic can_out;
    logic move;

    // The output register can take a new result when empty or being drained.
    assign can_out     = !r_out_vld || o_out.ready;
    assign o_cmd_ready = !r_hold_vld || can_out;
    assign move        = (i_cmd.push || i_cmd.flush) && r_hold_vld && can_out;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.push && o_cmd_ready) begin
                r_hold_vld <= 1'b1;
            end else if (i_cmd.flush && o_cmd_ready) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out      <= r_hold;
            r_out_last <= i_cmd.flush;
        end
        if (i_cmd.push && o_cmd_ready) begin
            r_hold <= i_cmd.res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.symbol_out = r_out.sym;
    assign o_out.kind       = r_out.kind;
    assign o_out.status     = r_out.status;
    assign o_out.last       = r_out_last;

endmodule

`default_nettype wire

>>> design/htd_walk.sv
// ============================================================================
// Huffman tree decoder walk sequencer
// Walks the node table one bit per step for inserts and decodes; inserts
// read, modify and write back node entries, decodes only read them.
// ============================================================================
`default_nettype none

module htd_walk
    import htd_pkg::*;
#(
    parameter int NODES        = 512,
    parameter int MAX_CODE_LEN = 32,
    parameter int IW           = 9,
    parameter int EW           = 27
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    htd_in_if.sink             i_in,
    output logic               o_rd_en,
    output logic [IW-1:0]      o_rd_addr,
    input  wire logic [EW-1:0] i_rd_data,
    output logic               o_wr_en,
    output logic [IW-1:0]      o_wr_addr,
    output logic [EW-1:0]      o_wr_data,
    output t_res_cmd           o_cmd,
    input  wire logic          i_cmd_ready
);

    localparam int CW     = $clog2(NODES + 1);
    localparam int LenLim = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;
    localparam logic [CW-1:0] NodesC = CW'(NODES);

    t_state r_state, n_state;

    logic [CodeW-1:0] r_code, n_code;
    logic [4:0]       r_bpos, n_bpos;
    logic [SymW-1:0]  r_sym, n_sym;
    logic [IW-1:0]    r_node, n_node;
    logic [IW-1:0]    r_new, n_new;
    logic [IW-1:0]    r_cur, n_cur;
    logic [SymW-1:0]  r_data, n_data;
    logic [CntW-1:0]  r_left, n_left;
    t_status          r_status, n_status;
    logic [CW-1:0]    r_count, n_count;
    logic             r_root_vld, n_root_vld;
    logic             r_rd_ok, n_rd_ok;

    logic [EW-1:0]    ent;
    logic [IW-1:0]    ent_left, ent_right, slot;
    logic [SymW-1:0]  ent_sym;
    logic             ent_leaf;
    logic             code_bit, walk_bit, final_bit, len_bad, table_full;
    logic [CntW-1:0]  cnt_sat;

    // A node entry read before it was ever written reads as an empty node.
    assign ent       = r_rd_ok ? i_rd_data : '0;
    assign ent_left  = ent[EW-1 -: IW];
    assign ent_right = ent[EW-1-IW -: IW];
    assign ent_sym   = ent[SymW:1];
    assign ent_leaf  = ent[0];

    // Decode steps pick the child by the leading data bit, inserts by the code bit.
    assign code_bit   = r_code[r_bpos];
    assign walk_bit   = (r_state == W_D_EV) ? r_data[SymW-1] : code_bit;
    assign final_bit  = (r_bpos == 5'd0);
    assign slot       = walk_bit ? ent_right : ent_left;
    assign table_full = (r_count >= NodesC);
    assign len_bad    = (i_in.code_len == '0) || (i_in.code_len > LenW'(LenLim));
    assign cnt_sat    = (i_in.bit_count > CntW'(8)) ? CntW'(8) : i_in.bit_count;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            W_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.mode == MODE_INSERT) begin
                        n_state = len_bad ? W_RES : W_I_RD;
                    end else begin
                        n_state = (cnt_sat == '0) ? W_END : W_D_RD;
                    end
                end
            end
            W_I_RD: n_state = W_I_EV;
            W_I_EV: begin
                if (ent_leaf || (slot != '0 && final_bit) || (slot == '0 && table_full)) begin
                    n_state = W_RES;
                end else if (slot != '0) begin
                    n_state = W_I_RD;
                end else begin
                    n_state = W_I_WN;
                end
            end
            W_I_WN:  n_state = final_bit ? W_RES : W_I_RD;
            W_RES:   n_state = i_cmd_ready ? W_END : W_RES;
            W_D_RD:  n_state = W_D_EV;
            W_D_EV: begin
                if (slot == '0) begin
                    n_state = i_cmd_ready ? W_END : W_D_EV;
                end else begin
                    n_state = W_D_CHK;
                end
            end
            W_D_CHK: begin
                if (ent_leaf) begin
                    if (i_cmd_ready) begin
                        n_state = (r_left == '0) ? W_END : W_D_RD;
                    end
                end else begin
                    n_state = (r_left == '0) ? W_END : W_D_EV;
                end
            end
            W_END:   n_state = i_cmd_ready ? W_IDLE : W_END;
            default: n_state = W_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        n_code     = r_code;
        n_bpos     = r_bpos;
        n_sym      = r_sym;
        n_node     = r_node;
        n_new      = r_new;
        n_cur      = r_cur;
        n_data     = r_data;
        n_left     = r_left;
        n_status   = r_status;
        n_count    = r_count;
        n_root_vld = r_root_vld;
        i_in.ready = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_node;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_node;
        o_wr_data  = '0;
        o_cmd      = '0;
        unique case (r_state)
            W_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_code   = i_in.code_bits;
                    n_bpos   = i_in.code_len[4:0] - 5'd1;
                    n_sym    = i_in.symbol_in;
                    n_node   = '0;
                    n_data   = i_in.data_byte;
                    n_left   = cnt_sat;
                    n_status = ST_CONFLICT;
                end
            end
            W_I_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_node;
            end
            W_I_EV: begin
                if (ent_leaf || (slot != '0 && final_bit)) begin
                    n_status = ST_CONFLICT;
                end else if (slot != '0) begin
                    n_node = slot;
                    n_bpos = r_bpos - 5'd1;
                end else if (table_full) begin
                    n_status = ST_FULL;
                end else begin
                    // Hook the new node into the parent.
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_node;
                    o_wr_data = code_bit ? {ent_left, r_count[IW-1:0], ent_sym, ent_leaf}
                                         : {r_count[IW-1:0], ent_right, ent_sym, ent_leaf};
                    n_new     = r_count[IW-1:0];
                    n_count   = r_count + CW'(1);
                    if (r_node == '0) begin
                        n_root_vld = 1'b1;
                    end
                end
            end
            W_I_WN: begin
                // Fill the new node: a leaf on the final bit, else empty.
                o_wr_en   = 1'b1;
                o_wr_addr = r_new;
                o_wr_data = {{(2*IW){1'b0}}, final_bit ? r_sym : {SymW{1'b0}}, final_bit};
                n_node    = r_new;
                n_bpos    = r_bpos - 5'd1;
                if (final_bit) begin
                    n_status = ST_OK;
                end
            end
            W_RES: begin
                o_cmd.push       = 1'b1;
                o_cmd.res.sym    = '0;
                o_cmd.res.kind   = KIND_RPT;
                o_cmd.res.status = r_status;
            end
            W_D_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_cur;
            end
            W_D_EV: begin
                if (slot == '0) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.res.sym    = '0;
                    o_cmd.res.kind   = KIND_RPT;
                    o_cmd.res.status = ST_MISSING;
                    if (i_cmd_ready) begin
                        n_cur = '0;
                    end
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = slot;
                    n_cur     = slot;
                    n_data    = {r_data[SymW-2:0], 1'b0};
                    n_left    = r_left - CntW'(1);
                end
            end
            W_D_CHK: begin
                if (ent_leaf) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.res.sym    = ent_sym;
                    o_cmd.res.kind   = KIND_SYM;
                    o_cmd.res.status = ST_OK;
                    if (i_cmd_ready) begin
                        n_cur = '0;
                    end
                end
            end
            W_END: begin
                o_cmd.flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // A read is valid once its entry has been written since reset.
    assign n_rd_ok = (o_rd_addr == '0) ? r_root_vld : (CW'(o_rd_addr) < r_count);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= W_IDLE;
            r_count    <= CW'(1);
            r_cur      <= '0;
            r_root_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cur      <= n_cur;
            r_root_vld <= n_root_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_bpos   <= n_bpos;
        r_sym    <= n_sym;
        r_node   <= n_node;
        r_new    <= n_new;
        r_data   <= n_data;
        r_left   <= n_left;
        r_status <= n_status;
        if (o_rd_en) begin
            r_rd_ok <= n_rd_ok;
        end
    end

endmodule

`default_nettype wire

>>> design/huffman_tree_decoder_unit.sv
// ============================================================================
// Huffman tree decoder unit
// Node-table Huffman decoder: builds the code tree from insert requests and
// decodes coded bytes into symbols.
// ============================================================================
// The code tree lives in one node memory of NODES entries with a registered
// read, and one request is worked on at a time. An insert of an L-bit code
// reads the node for each bit in turn, hooks a new node into the parent
// where a bit has no child yet and fills it, and gives one status result.
// A decode request needs a dependent child lookup in the node memory for
// every coded bit and starts again at the root after each emitted symbol;
// a full byte with no missing child may give zero to eight results, the
// final one flagged last. The table is empty after reset with no clearing
// pass: unused entries are tracked by the node count and a root-valid flag.
// A result waits in an output register, so the next request is taken while
// the previous result is still pending downstream.
// ============================================================================
`default_nettype none

module huffman_tree_decoder_unit
    import htd_pkg::*;
#(
    parameter int NODES        = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    htd_in_if.sink    i_in,
    htd_out_if.source o_out
);

    localparam int IW = $clog2(NODES);
    localparam int EW = 2 * IW + SymW + 1;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    t_res_cmd      cmd;
    logic          cmd_ready;

    // Node table.
    htd_node_mem #(
        .DEPTH (NODES),
        .AW    (IW),
        .DW    (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Tree walk sequencer.
    htd_walk #(
        .NODES        (NODES),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .IW           (IW),
        .EW           (EW)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    // Result hold and output register.
    htd_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
